[hdl/lqsr_pkg.sv]
// Shared types and constants for the linear queue with search and replace.
`timescale 1ns / 1ps

package lqsr_pkg;

    // Queue geometry
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_MODIFY  = 2'd2,
        CMD_DISPLAY = 2'd3
    } t_cmd;

    // Result codes carried on the output tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    accept;    // capture the input beat, point the scan at the head
        logic    push;      // append the captured value
        logic    pop;       // retire the head entry
        logic    mod_write; // overwrite the slot under the scan pointer
        logic    ptr_inc;   // advance the scan pointer
        logic    load_out;  // fill the output register
        t_status out_status;
        logic    out_data;  // 1: slot read data, 0: zero
        logic    out_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic match;
        logic at_tail;
        logic out_free;
    } t_dp_stat;

endpackage

[hdl/linear_queue_with_search_replace.sv]
// Top level: linear array queue with push, pop, search-and-replace and display.
`timescale 1ns / 1ps

// Non-circular queue of CAPACITY signed 32-bit entries held in a small
// memory with one write port and one registered read port. One beat is
// taken at a time. Modify searches slot by slot from the head, and display
// emits entry by entry, as the read port delivers one slot per cycle.
// Results sit in an output register, so a beat stalls only while that
// register is full and not being taken. Push reports overflow once the
// tail reaches the last slot; freed slots are reused only after the queue
// drains. No clearing pass after reset: slots are read only once written.
module linear_queue_with_search_replace (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] value, [63:32] new_value
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] data
    output logic [1:0]  m_axis_tuser,  // [1:0] status
    output logic        m_axis_tlast
);
    import lqsr_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    lqsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    lqsr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_axis_tuser),
        .i_value      (s_axis_tdata[31:0]),
        .i_new_value  (s_axis_tdata[63:32]),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

[hdl/lqsr_dp.sv]
// Datapath: slot memory, head/tail indices, scan pointer and output register.
`timescale 1ns / 1ps

module lqsr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_cmd,
    input  logic [lqsr_pkg::DATA_W-1:0]   i_value,
    input  logic [lqsr_pkg::DATA_W-1:0]   i_new_value,
    input  lqsr_pkg::t_dp_cmd             i_ctl,
    output lqsr_pkg::t_dp_stat            o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_out_status,
    output logic [lqsr_pkg::DATA_W-1:0]   o_out_data,
    output logic                          o_out_last
);
    import lqsr_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];

    logic [IDX_W-1:0]  r_head, r_tail, r_ptr, n_ptr;
    logic              r_empty;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_value, r_new_value, r_rd_data;
    logic              r_out_valid, r_out_last;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_data;

    logic              full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign full = (r_tail == IDX_W'(CAPACITY - 1));

    // Scan pointer: loaded with the head on a new beat, stepped during a scan
    always_comb begin
        n_ptr = r_ptr;
        if (i_ctl.accept) begin
            n_ptr = r_head;
        end else if (i_ctl.ptr_inc) begin
            n_ptr = r_ptr + IDX_W'(1);
        end
    end

    // Single write port: push appends, modify overwrites at the pointer
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = r_new_value;
        if (i_ctl.push && (r_empty || !full)) begin
            wr_en   = 1'b1;
            wr_addr = r_empty ? '0 : r_tail + IDX_W'(1);
            wr_data = r_value;
        end else if (i_ctl.mod_write) begin
            wr_en = 1'b1;
        end
    end

    // Slot memory, read data registered at the pointer's next value
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[n_ptr];
    end

    // Captured beat and scan pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd       <= t_cmd'(i_cmd);
            r_value     <= i_value;
            r_new_value <= i_new_value;
        end
        r_ptr <= n_ptr;
    end

    // Queue indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_ctl.push) begin
            if (r_empty) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_empty <= 1'b0;
            end else if (!full) begin
                r_tail <= r_tail + IDX_W'(1);
            end
        end else if (i_ctl.pop) begin
            if (r_head == r_tail) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_empty <= 1'b1;
            end else begin
                r_head <= r_head + IDX_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_status <= i_ctl.out_status;
            r_out_data   <= i_ctl.out_data ? r_rd_data : '0;
            r_out_last   <= i_ctl.out_last;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.empty    = r_empty;
    assign o_stat.full     = full;
    assign o_stat.match    = (r_rd_data == r_value);
    assign o_stat.at_tail  = (r_ptr == r_tail);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

endmodule

[hdl/lqsr_ctrl.sv]
// Controller: sequences push, pop, modify search and display over the datapath.
`timescale 1ns / 1ps

module lqsr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lqsr_pkg::t_dp_stat  i_stat,
    output lqsr_pkg::t_dp_cmd   o_ctl
);
    import lqsr_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                // every result here goes straight out, so wait for a free slot
                if (i_stat.out_free) begin
                    case (i_stat.cmd)
                        CMD_PUSH: begin
                            o_ctl.push       = 1'b1;
                            o_ctl.load_out   = 1'b1;
                            o_ctl.out_last   = 1'b1;
                            o_ctl.out_status = (!i_stat.empty && i_stat.full) ?
                                               ST_OVERFLOW : ST_OK;
                            n_state          = S_IDLE;
                        end
                        CMD_MODIFY: begin
                            if (i_stat.empty) begin
                                o_ctl.load_out   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_NOT_FOUND;
                                n_state          = S_IDLE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // pop and display
                            if (i_stat.empty) begin
                                o_ctl.load_out   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_EMPTY;
                                n_state          = S_IDLE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (i_stat.cmd)
                    CMD_POP: begin
                        if (i_stat.out_free) begin
                            o_ctl.pop        = 1'b1;
                            o_ctl.load_out   = 1'b1;
                            o_ctl.out_data   = 1'b1;
                            o_ctl.out_last   = 1'b1;
                            o_ctl.out_status = ST_OK;
                            n_state          = S_IDLE;
                        end
                    end
                    CMD_DISPLAY: begin
                        if (i_stat.out_free) begin
                            o_ctl.load_out   = 1'b1;
                            o_ctl.out_data   = 1'b1;
                            o_ctl.out_last   = i_stat.at_tail;
                            o_ctl.out_status = ST_OK;
                            if (i_stat.at_tail) begin
                                n_state = S_IDLE;
                            end else begin
                                o_ctl.ptr_inc = 1'b1;
                            end
                        end
                    end
                    CMD_MODIFY: begin
                        if (i_stat.match) begin
                            if (i_stat.out_free) begin
                                o_ctl.mod_write  = 1'b1;
                                o_ctl.load_out   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_OK;
                                n_state          = S_IDLE;
                            end
                        end else if (i_stat.at_tail) begin
                            if (i_stat.out_free) begin
                                o_ctl.load_out   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_NOT_FOUND;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_ctl.ptr_inc = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[tb/tb.sv]
// Self-checking testbench for the linear queue with search and replace.
`timescale 1ns / 1ps

module tb;

    import lqsr_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_BEATS   = 195;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;

    // One expected output beat
    typedef struct {
        t_status     status;
        logic [31:0] data;
        logic        last;
    } t_result;

    // One row of the directed table; typed rows carry their own answer
    typedef struct {
        t_cmd        cmd;
        logic [31:0] value;
        logic [31:0] new_value;
        bit          typed;
        t_status     status;
        logic [31:0] data;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] value, [63:32] new_value
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] data
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        m_axis_tlast;

    // Shadow copy of the queue
    logic [31:0]      q_slots [CAPACITY];
    logic [IDX_W-1:0] q_head;
    logic [IDX_W-1:0] q_tail;
    logic             q_empty;

    t_result pending_results [$];
    t_row    dir_rows [$];

    int  error_count   = 0;
    int  beats_in      = 0;
    int  results_seen  = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  gaps_on       = 1'b1;
    bit  hold_req      = 1'b0;

    linear_queue_with_search_replace u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Queue an expectation unless the caller supplies its own
    task automatic add_expected(input t_status st, input logic [31:0] d, input logic l,
                                input bit record);
        t_result r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        if (record) pending_results.push_back(r);
    endtask

    // Apply one accepted beat to the shadow queue and predict its results
    task automatic queue_apply(input t_cmd cmd, input logic [31:0] value,
                               input logic [31:0] new_value, input bit record);
        int i;
        bit hit;
        hit = 1'b0;
        case (cmd)
            CMD_PUSH: begin
                if (q_empty) begin
                    q_head     = '0;
                    q_tail     = '0;
                    q_slots[0] = value;
                    q_empty    = 1'b0;
                    add_expected(ST_OK, '0, 1'b1, record);
                end else if (q_tail == IDX_W'(CAPACITY - 1)) begin
                    // full once the tail is on the last slot, freed slots or not
                    add_expected(ST_OVERFLOW, '0, 1'b1, record);
                end else begin
                    q_tail          = q_tail + IDX_W'(1);
                    q_slots[q_tail] = value;
                    add_expected(ST_OK, '0, 1'b1, record);
                end
            end
            CMD_POP: begin
                if (q_empty) begin
                    add_expected(ST_EMPTY, '0, 1'b1, record);
                end else begin
                    add_expected(ST_OK, q_slots[q_head], 1'b1, record);
                    if (q_head == q_tail) begin
                        q_empty = 1'b1;
                        q_head  = '0;
                        q_tail  = '0;
                    end else begin
                        q_head = q_head + IDX_W'(1);
                    end
                end
            end
            CMD_MODIFY: begin
                // first match from head to tail wins
                if (!q_empty) begin
                    for (i = int'(q_head); i <= int'(q_tail) && !hit; i++) begin
                        if (q_slots[i] == value) begin
                            q_slots[i] = new_value;
                            hit        = 1'b1;
                        end
                    end
                end
                add_expected(hit ? ST_OK : ST_NOT_FOUND, '0, 1'b1, record);
            end
            default: begin
                if (q_empty) begin
                    add_expected(ST_EMPTY, '0, 1'b1, record);
                end else begin
                    for (i = int'(q_head); i <= int'(q_tail); i++)
                        add_expected(ST_OK, q_slots[i], i == int'(q_tail), record);
                end
            end
        endcase
    endtask

    function automatic t_row mk_row(input t_cmd c, input logic [31:0] v,
                                    input logic [31:0] nv, input bit typed,
                                    input t_status st, input logic [31:0] d);
        t_row r;
        r.cmd       = c;
        r.value     = v;
        r.new_value = nv;
        r.typed     = typed;
        r.status    = st;
        r.data      = d;
        return r;
    endfunction

    // Word with a bias towards extremes and small repeated values
    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 32'($urandom_range(0, 7));
        if (sel == 1) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one beat, with random gaps, and wait for it to be taken
    task automatic send_beat(input t_cmd cmd, input logic [31:0] value,
                             input logic [31:0] new_value, input bit typed,
                             input t_status st, input logic [31:0] d);
        while (gaps_on && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {new_value, value};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_in++;
        queue_apply(cmd, value, new_value, !typed);
        if (typed) add_expected(st, d, 1'b1, 1'b1);
    endtask

    // Compare one output beat with the oldest expectation
    task automatic check_result();
        t_result want;
        results_seen++;
        status_seen[m_axis_tuser]++;
        if (pending_results.size() == 0) begin
            $error("unexpected result beat: status %0d data %h last %b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            if (m_axis_tuser !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                error_count++;
            end
            if (m_axis_tdata !== want.data) begin
                $error("data: expected %h, got %h", want.data, m_axis_tdata);
                error_count++;
            end
            if (m_axis_tlast !== want.last) begin
                $error("last: expected %b, got %b", want.last, m_axis_tlast);
                error_count++;
            end
        end
    endtask

    // Result side: random back-pressure plus one long hold-off
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Watchdog: too long without any beat on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $error("watchdog: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int   n;
        int   dice;
        bit   filling;
        t_cmd cmd;
        logic [31:0] value;
        logic [31:0] new_value;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_PUSH;
        q_empty = 1'b1;
        q_head  = '0;
        q_tail  = '0;
        foreach (q_slots[k]) q_slots[k] = '0;

        // Directed: empty cases, fill to overflow, search, drain to empty
        dir_rows.push_back(mk_row(CMD_POP,     0, 0, 1, ST_EMPTY,     0));
        dir_rows.push_back(mk_row(CMD_DISPLAY, 0, 0, 1, ST_EMPTY,     0));
        dir_rows.push_back(mk_row(CMD_MODIFY,  0, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h8000_0000, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h7FFF_FFFF, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'hFFFF_FFFF, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h0000_0000, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h0000_0004, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h5555_5555, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'hAAAA_AAAA, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h1234_5678, 0, 1, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h0000_0001, 0, 1, ST_OVERFLOW, 0));
        dir_rows.push_back(mk_row(CMD_DISPLAY, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_MODIFY, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, ST_OK, 0));
        dir_rows.push_back(mk_row(CMD_MODIFY, 32'hDEAD_BEEF, 32'h0, 1, ST_NOT_FOUND, 0));
        dir_rows.push_back(mk_row(CMD_POP, 0, 0, 1, ST_OK, 32'h8000_0000));
        // freed head slot is not reused while entries remain
        dir_rows.push_back(mk_row(CMD_PUSH, 32'h0000_0002, 0, 1, ST_OVERFLOW, 0));
        // duplicates: only the first from the head is replaced
        dir_rows.push_back(mk_row(CMD_MODIFY, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, ST_OK, 0));
        repeat (7) dir_rows.push_back(mk_row(CMD_POP, 0, 0, 0, ST_OK, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_beat(dir_rows[r].cmd, dir_rows[r].value, dir_rows[r].new_value,
                      dir_rows[r].typed, dir_rows[r].status, dir_rows[r].data);

        // Random: alternate fill-heavy and drain-heavy spells
        filling = 1'b1;
        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 24 == 0) filling = !filling || (n == 0);
            if (n == 30) hold_req = 1'b1;
            gaps_on = !(n >= 120 && n < 180);

            dice = $urandom_range(0, 99);
            if (dice < 15)       cmd = CMD_MODIFY;
            else if (dice < 30)  cmd = CMD_DISPLAY;
            else if (dice < 85)  cmd = filling ? CMD_PUSH : CMD_POP;
            else                 cmd = filling ? CMD_POP : CMD_PUSH;

            value     = pick_word();
            new_value = pick_word();
            // most searches aim at a held entry
            if (cmd == CMD_MODIFY && !q_empty && $urandom_range(0, 9) < 7)
                value = q_slots[$urandom_range(int'(q_head), int'(q_tail))];

            send_beat(cmd, value, new_value, 1'b0, ST_OK, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d command beats in, %0d result beats checked", beats_in,
                 results_seen);
        $display("Statuses: ok %0d, overflow %0d, empty %0d, not found %0d",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_EMPTY],
                 status_seen[ST_NOT_FOUND]);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
